// File: rtl/core/jlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlt_pkg
// Shared types, character codes and literal tables for the JSON-lines
// line tokenizer.
// ----------------------------------------------------------------------------
package jlt_pkg;

  localparam int unsigned MAX_NEST_DEPTH_DEF = 255;

  // Result kinds.
  localparam logic [2:0] KIND_KEY_BYTE = 3'd0;
  localparam logic [2:0] KIND_VAL_BYTE = 3'd1;
  localparam logic [2:0] KIND_KEY_END  = 3'd2;
  localparam logic [2:0] KIND_VAL_END  = 3'd3;
  localparam logic [2:0] KIND_LINE_END = 3'd4;

  // Value types carried on a value end.
  localparam logic [2:0] VT_NULL   = 3'd0;
  localparam logic [2:0] VT_BOOL   = 3'd1;
  localparam logic [2:0] VT_INT    = 3'd2;
  localparam logic [2:0] VT_DOUBLE = 3'd3;
  localparam logic [2:0] VT_STRING = 3'd4;

  // Literal kinds.
  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  // Number phases.
  localparam logic [1:0] PH_INT   = 2'd0;
  localparam logic [1:0] PH_FRAC  = 2'd1;
  localparam logic [1:0] PH_ESIGN = 2'd2;
  localparam logic [1:0] PH_EDIG  = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [2:0] value_type;
    logic       bool_value;
    logic       line_ok;
    logic       last;
  } res_t;

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] data,
                                  input logic [2:0] vt, input logic bv,
                                  input logic ok);
    res_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.value_type = vt;
    r.bool_value = bv;
    r.line_ok    = ok;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Byte i of the literal of kind k ("null", "true", "false").
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      LIT_TRUE: begin
        case (i)
          3'd0:    c = 8'h74;
          3'd1:    c = 8'h72;
          3'd2:    c = 8'h75;
          3'd3:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (i)
          3'd0:    c = 8'h66;
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h73;
          3'd4:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (i)
          3'd0:    c = 8'h6E;
          3'd1:    c = 8'h75;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

// File: rtl/core/jsonl_line_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsonl_line_tokenizer_unit
// Checks one flat JSON object per line of a byte stream and emits key bytes,
// value bytes, key and value ends, and one line end per line.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in_      sink       in_valid / in_stall    in_byte_in, in_last_byte
//   out_     source     out_valid / out_stall  out_kind, out_data_byte,
//                                              out_value_type, out_bool_value,
//                                              out_line_ok, out_last
//
// One byte is accepted per cycle while in_stall is low. A byte is held in the
// input register and parsed there; its zero, one or two results enter a
// four-entry result queue and are presented on the output from its head. The
// queue drains one result per cycle while out_stall is low, so a run of bytes
// that each give two results is limited by the output port. A parsed byte needs
// two free queue slots, otherwise in_stall rises. Reset (synchronous, rst_n low)
// returns the parser to line start and empties the queue.
module jsonl_line_tokenizer_unit #(
  parameter int unsigned MAX_NEST_DEPTH = jlt_pkg::MAX_NEST_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_value_type,
  output logic       out_bool_value,
  output logic       out_line_ok,
  output logic       out_last
);

  localparam int unsigned DEPTH_W = $clog2(MAX_NEST_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NEST_DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

  typedef enum logic [3:0] {
    M_LINE, M_OPEN, M_KEY, M_AFTER_KEY, M_VSTART, M_LIT,
    M_VSTR, M_NUM, M_NEST, M_AFTER_VAL, M_SKIP
  } mode_t;

  // Input register.
  logic       stg_v_r, stg_v_nxt;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;

  // Parser state.
  mode_t              mode_r, mode_nxt;
  logic [1:0]         lit_kind_r, lit_kind_nxt;
  logic [2:0]         lit_idx_r, lit_idx_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic               esc_r, esc_nxt;
  logic [2:0]         hex_r, hex_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               brace_r, brace_nxt;

  // Result queue.
  jlt_pkg::res_t q_mem [4];
  logic [1:0]    wr_ptr_r, rd_ptr_r;
  logic [2:0]    cnt_r;

  logic          in_acc, pop, room, proc;
  logic [7:0]    b;
  logic          c0_v, c1_v, c2_v;
  jlt_pkg::res_t c0, c1, c2, r0, r1;
  logic [1:0]    n_res;
  mode_t         fail_mode, av_mode;
  logic          av_emit;
  jlt_pkg::res_t av_res;
  logic          str_kind_val;
  logic          num_take;
  logic [1:0]    num_next;
  logic [1:0]    lk;
  logic [7:0]    open_ch, close_ch;
  logic [7:0]    esc_data;

  assign b         = stg_byte_r;
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= 3'd2) || (pop && (cnt_r == 3'd3));
  assign proc      = stg_v_r && room;
  assign in_stall  = stg_v_r && !room;
  assign in_acc    = in_valid && !in_stall;
  assign stg_v_nxt = in_acc ? 1'b1 : (proc ? 1'b0 : stg_v_r);

  assign fail_mode = (b == jlt_pkg::CH_LF) ? M_LINE : M_SKIP;

  // Handling of a byte that follows a complete value.
  always_comb begin
    av_emit = 1'b0;
    av_res  = jlt_pkg::mk_res(jlt_pkg::KIND_LINE_END, 8'h00, jlt_pkg::VT_NULL, 1'b0, 1'b0);
    av_mode = M_AFTER_VAL;
    if (jlt_pkg::is_ws(b)) begin
      av_mode = M_AFTER_VAL;
    end else if (b == jlt_pkg::CH_COMMA) begin
      av_mode = M_OPEN;
    end else if (b == jlt_pkg::CH_RBRACE) begin
      av_emit        = 1'b1;
      av_res.line_ok = 1'b1;
      av_mode        = M_SKIP;
    end else begin
      av_emit = 1'b1;
      av_mode = fail_mode;
    end
  end

  always_comb begin
    case (b)
      jlt_pkg::CH_LO_B: esc_data = jlt_pkg::CH_BS;
      jlt_pkg::CH_LO_F: esc_data = jlt_pkg::CH_FF;
      jlt_pkg::CH_LO_N: esc_data = jlt_pkg::CH_LF;
      jlt_pkg::CH_LO_R: esc_data = jlt_pkg::CH_CR;
      jlt_pkg::CH_LO_T: esc_data = jlt_pkg::CH_TAB;
      default:          esc_data = b;
    endcase
  end

  // Number grammar: which bytes continue the number and the phase after them.
  always_comb begin
    num_take = 1'b0;
    num_next = phase_r;
    case (phase_r)
      jlt_pkg::PH_INT: begin
        if (jlt_pkg::is_digit(b)) begin
          num_take = 1'b1;
        end else if (b == jlt_pkg::CH_DOT) begin
          num_take = 1'b1;
          num_next = jlt_pkg::PH_FRAC;
        end else if (b == jlt_pkg::CH_LO_E || b == jlt_pkg::CH_UP_E) begin
          num_take = 1'b1;
          num_next = jlt_pkg::PH_ESIGN;
        end
      end
      jlt_pkg::PH_FRAC: begin
        if (jlt_pkg::is_digit(b)) begin
          num_take = 1'b1;
        end else if (b == jlt_pkg::CH_LO_E || b == jlt_pkg::CH_UP_E) begin
          num_take = 1'b1;
          num_next = jlt_pkg::PH_ESIGN;
        end
      end
      jlt_pkg::PH_ESIGN: begin
        if (jlt_pkg::is_digit(b) || b == jlt_pkg::CH_PLUS || b == jlt_pkg::CH_MINUS) begin
          num_take = 1'b1;
          num_next = jlt_pkg::PH_EDIG;
        end
      end
      default: begin
        num_take = jlt_pkg::is_digit(b);
      end
    endcase
  end

  assign lk           = (lit_kind_r == 2'd3) ? jlt_pkg::LIT_NULL : lit_kind_r;
  assign open_ch      = brace_r ? jlt_pkg::CH_LBRACE : jlt_pkg::CH_LBRACK;
  assign close_ch     = brace_r ? jlt_pkg::CH_RBRACE : jlt_pkg::CH_RBRACK;
  assign str_kind_val = (mode_r == M_VSTR);

  // One parse step for the byte in the input register.
  always_comb begin
    mode_nxt     = mode_r;
    lit_kind_nxt = lit_kind_r;
    lit_idx_nxt  = lit_idx_r;
    phase_nxt    = phase_r;
    esc_nxt      = esc_r;
    hex_nxt      = hex_r;
    depth_nxt    = depth_r;
    brace_nxt    = brace_r;
    c0_v = 1'b0;
    c1_v = 1'b0;
    c0   = jlt_pkg::mk_res(jlt_pkg::KIND_LINE_END, 8'h00, jlt_pkg::VT_NULL, 1'b0, 1'b0);
    c1   = av_res;
    case (mode_r)
      M_LINE: begin
        if (!jlt_pkg::is_ws(b)) begin
          if (b == jlt_pkg::CH_LBRACE) begin
            mode_nxt = M_OPEN;
          end else begin
            c0_v     = 1'b1;
            mode_nxt = fail_mode;
          end
        end
      end
      M_OPEN: begin
        if (!jlt_pkg::is_ws(b)) begin
          if (b == jlt_pkg::CH_RBRACE) begin
            c0_v       = 1'b1;
            c0.line_ok = 1'b1;
            mode_nxt   = M_SKIP;
          end else if (b == jlt_pkg::CH_QUOTE) begin
            mode_nxt = M_KEY;
            esc_nxt  = 1'b0;
            hex_nxt  = 3'd0;
          end else begin
            c0_v     = 1'b1;
            mode_nxt = fail_mode;
          end
        end
      end
      M_KEY, M_VSTR: begin
        if (hex_r != 3'd0) begin
          hex_nxt = hex_r - 3'd1;
        end else if (esc_r) begin
          esc_nxt = 1'b0;
          if (b == jlt_pkg::CH_LO_U) begin
            hex_nxt = 3'd4;
          end else begin
            c0_v = 1'b1;
            c0   = jlt_pkg::mk_res(str_kind_val ? jlt_pkg::KIND_VAL_BYTE
                                                : jlt_pkg::KIND_KEY_BYTE,
                                   esc_data, jlt_pkg::VT_NULL, 1'b0, 1'b0);
          end
        end else if (b == jlt_pkg::CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (b == jlt_pkg::CH_QUOTE) begin
          c0_v = 1'b1;
          if (str_kind_val) begin
            c0 = jlt_pkg::mk_res(jlt_pkg::KIND_VAL_END, 8'h00, jlt_pkg::VT_STRING,
                                 1'b0, 1'b0);
            mode_nxt = M_AFTER_VAL;
          end else begin
            c0 = jlt_pkg::mk_res(jlt_pkg::KIND_KEY_END, 8'h00, jlt_pkg::VT_NULL,
                                 1'b0, 1'b0);
            mode_nxt = M_AFTER_KEY;
          end
        end else begin
          c0_v = 1'b1;
          c0   = jlt_pkg::mk_res(str_kind_val ? jlt_pkg::KIND_VAL_BYTE
                                              : jlt_pkg::KIND_KEY_BYTE,
                                 b, jlt_pkg::VT_NULL, 1'b0, 1'b0);
        end
      end
      M_AFTER_KEY: begin
        if (!jlt_pkg::is_ws(b)) begin
          if (b == jlt_pkg::CH_COLON) begin
            mode_nxt = M_VSTART;
          end else begin
            c0_v     = 1'b1;
            mode_nxt = fail_mode;
          end
        end
      end
      M_VSTART: begin
        if (jlt_pkg::is_ws(b)) begin
          mode_nxt = M_VSTART;
        end else if (b == jlt_pkg::CH_LO_N || b == jlt_pkg::CH_LO_T
                     || b == jlt_pkg::CH_LO_F) begin
          lit_kind_nxt = (b == jlt_pkg::CH_LO_N) ? jlt_pkg::LIT_NULL :
                         (b == jlt_pkg::CH_LO_T) ? jlt_pkg::LIT_TRUE : jlt_pkg::LIT_FALSE;
          lit_idx_nxt  = 3'd1;
          mode_nxt     = M_LIT;
        end else if (b == jlt_pkg::CH_QUOTE) begin
          mode_nxt = M_VSTR;
          esc_nxt  = 1'b0;
          hex_nxt  = 3'd0;
        end else if (b == jlt_pkg::CH_MINUS || b == jlt_pkg::CH_PLUS
                     || jlt_pkg::is_digit(b)) begin
          c0_v      = 1'b1;
          c0        = jlt_pkg::mk_res(jlt_pkg::KIND_VAL_BYTE, b, jlt_pkg::VT_NULL,
                                      1'b0, 1'b0);
          phase_nxt = jlt_pkg::PH_INT;
          mode_nxt  = M_NUM;
        end else if (b == jlt_pkg::CH_LBRACK || b == jlt_pkg::CH_LBRACE) begin
          brace_nxt = (b == jlt_pkg::CH_LBRACE);
          depth_nxt = DEPTH_ONE;
          mode_nxt  = M_NEST;
        end else begin
          c0_v     = 1'b1;
          mode_nxt = fail_mode;
        end
      end
      M_LIT: begin
        if ((lit_idx_r < jlt_pkg::lit_len(lk)) && (b == jlt_pkg::lit_char(lk, lit_idx_r)))
        begin
          lit_idx_nxt = lit_idx_r + 3'd1;
          if (lit_idx_r + 3'd1 == jlt_pkg::lit_len(lk)) begin
            c0_v     = 1'b1;
            c0       = jlt_pkg::mk_res(jlt_pkg::KIND_VAL_END, 8'h00,
                                       (lk == jlt_pkg::LIT_NULL) ? jlt_pkg::VT_NULL
                                                                 : jlt_pkg::VT_BOOL,
                                       (lk == jlt_pkg::LIT_TRUE), 1'b0);
            mode_nxt = M_AFTER_VAL;
          end
        end else begin
          c0_v     = 1'b1;
          mode_nxt = fail_mode;
        end
      end
      M_NUM: begin
        if (num_take) begin
          c0_v      = 1'b1;
          c0        = jlt_pkg::mk_res(jlt_pkg::KIND_VAL_BYTE, b, jlt_pkg::VT_NULL,
                                      1'b0, 1'b0);
          phase_nxt = num_next;
        end else begin
          // The terminating byte closes the number and is then parsed as
          // the byte after a value.
          c0_v     = 1'b1;
          c0       = jlt_pkg::mk_res(jlt_pkg::KIND_VAL_END, 8'h00,
                                     (phase_r == jlt_pkg::PH_INT) ? jlt_pkg::VT_INT
                                                                  : jlt_pkg::VT_DOUBLE,
                                     1'b0, 1'b0);
          c1_v     = av_emit;
          mode_nxt = av_mode;
        end
      end
      M_NEST: begin
        if (b == open_ch) begin
          if (depth_r >= DEPTH_MAX) begin
            c0_v     = 1'b1;
            mode_nxt = fail_mode;
          end else begin
            depth_nxt = depth_r + DEPTH_ONE;
          end
        end else if (b == close_ch) begin
          depth_nxt = depth_r - DEPTH_ONE;
          if (depth_r == DEPTH_ONE) begin
            c0_v     = 1'b1;
            c0       = jlt_pkg::mk_res(jlt_pkg::KIND_VAL_END, 8'h00, jlt_pkg::VT_NULL,
                                       1'b0, 1'b0);
            mode_nxt = M_AFTER_VAL;
          end
        end
      end
      M_AFTER_VAL: begin
        c0_v     = av_emit;
        c0       = av_res;
        mode_nxt = av_mode;
      end
      default: begin
        if (b == jlt_pkg::CH_LF) begin
          mode_nxt = M_LINE;
        end
      end
    endcase

    // End of data: an open line is closed with an error and state resets.
    c2_v = stg_last_r && (mode_nxt != M_LINE) && (mode_nxt != M_SKIP);
    c2   = jlt_pkg::mk_res(jlt_pkg::KIND_LINE_END, 8'h00, jlt_pkg::VT_NULL, 1'b0, 1'b0);
    if (stg_last_r) begin
      mode_nxt     = M_LINE;
      lit_kind_nxt = jlt_pkg::LIT_NULL;
      lit_idx_nxt  = 3'd0;
      phase_nxt    = jlt_pkg::PH_INT;
      esc_nxt      = 1'b0;
      hex_nxt      = 3'd0;
      depth_nxt    = '0;
      brace_nxt    = 1'b0;
    end
  end

  // Keep the first two candidate results in order and mark the final one.
  always_comb begin
    r0 = c0_v ? c0 : (c1_v ? c1 : c2);
    r1 = (c0_v && c1_v) ? c1 : c2;
    n_res = {1'b0, c0_v} + {1'b0, c1_v} + {1'b0, c2_v};
    if (n_res == 2'd3) begin
      n_res = 2'd2;
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r    <= 1'b0;
      mode_r     <= M_LINE;
      lit_kind_r <= jlt_pkg::LIT_NULL;
      lit_idx_r  <= 3'd0;
      phase_r    <= jlt_pkg::PH_INT;
      esc_r      <= 1'b0;
      hex_r      <= 3'd0;
      depth_r    <= '0;
      brace_r    <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      if (proc) begin
        mode_r     <= mode_nxt;
        lit_kind_r <= lit_kind_nxt;
        lit_idx_r  <= lit_idx_nxt;
        phase_r    <= phase_nxt;
        esc_r      <= esc_nxt;
        hex_r      <= hex_nxt;
        depth_r    <= depth_nxt;
        brace_r    <= brace_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_byte_in;
      stg_last_r <= in_last_byte;
    end
  end

  // Result queue storage and pointers.
  always_ff @(posedge clk) begin
    if (proc && (n_res != 2'd0)) begin
      q_mem[wr_ptr_r] <= r0;
    end
    if (proc && (n_res == 2'd2)) begin
      q_mem[wr_ptr_r + 2'd1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + (proc ? n_res : 2'd0);
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_r + {1'b0, (proc ? n_res : 2'd0)} - {2'b00, pop};
    end
  end

  assign out_valid      = (cnt_r != 3'd0);
  assign out_kind       = q_mem[rd_ptr_r].kind;
  assign out_data_byte  = q_mem[rd_ptr_r].data_byte;
  assign out_value_type = q_mem[rd_ptr_r].value_type;
  assign out_bool_value = q_mem[rd_ptr_r].bool_value;
  assign out_line_ok    = q_mem[rd_ptr_r].line_ok;
  assign out_last       = q_mem[rd_ptr_r].last;

endmodule
